[hw/rtl/fuzzy_steering_centroid_macros.svh]
// assertion helpers for the steering controller
`ifndef FUZZY_STEERING_CENTROID_MACROS_SVH
`define FUZZY_STEERING_CENTROID_MACROS_SVH

`ifndef SYNTHESIS
// condition must hold whenever the antecedent holds
`define FSC_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("fsc assertion failed");
// condition must hold in the cycle after the antecedent
`define FSC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("fsc assertion failed");
`else
`define FSC_ASSERT_IMPLY(label, ante, cons)
`define FSC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hw/rtl/fsc_pkg.sv]
package fsc_pkg;

   // default parameter values
   localparam int SENSOR_BITS_DEF   = 10;
   localparam int HALF_UNIVERSE_DEF = 50;

   // datapath widths, sized for the largest supported universe
   localparam int DEG_BITS    = 15;
   localparam int WEIGHT_BITS = 24;
   localparam int MOMENT_BITS = 30;
   localparam int CFG_BITS    = 12;
   localparam int DRIVE_BITS  = 13;
   localparam int K_BITS      = 7;
   localparam int TAB_DEPTH   = 65;
   localparam int TRI_BITS    = 12;
   localparam int PYR_BITS    = 17;
   localparam int VN_DEPTH    = 128;

   // membership breakpoints
   localparam int FULL_DEG     = 25600;
   localparam int NEAR_LO      = 300;
   localparam int NEAR_MID     = 600;
   localparam int NEAR_HI      = 900;
   localparam int VN_TOP       = 1023;
   localparam int VN_SPAN      = 123;
   localparam int AROUND_START = 45;

   // register resets and drive limits
   localparam logic [CFG_BITS-1:0] FWD_SPEED_RESET = 12'd1024;
   localparam logic [CFG_BITS-1:0] GAIN_RESET      = 12'd410;
   localparam int DRIVE_MAX = 4095;
   localparam int DRIVE_MIN = -4096;

   typedef enum logic [0:0] {
      CSR_FORWARD_SPEED = 1'b0,
      CSR_STEERING_GAIN = 1'b1
   } csr_index_type;

   // flags that ride along with a division
   typedef struct packed {
      logic neg;
      logic zero;
   } div_tag_type;

   // weight and moment magnitude of one clipped output set
   typedef struct packed {
      logic [WEIGHT_BITS-1:0] weight;
      logic [MOMENT_BITS-1:0] moment;
   } ramp_sum_type;

   // very-near degree for offsets above the lower breakpoint
   function automatic logic [VN_DEPTH-1:0][DEG_BITS-1:0] build_vn_tab();
      logic [VN_DEPTH-1:0][DEG_BITS-1:0] t;
      for (int x = 0; x < VN_DEPTH; x++) begin
         t[x] = (x < VN_SPAN) ? DEG_BITS'((x * FULL_DEG) / VN_SPAN) : DEG_BITS'(FULL_DEG);
      end
      return t;
   endfunction

   // triangular numbers k(k+1)/2
   function automatic logic [TAB_DEPTH-1:0][TRI_BITS-1:0] build_tri();
      logic [TAB_DEPTH-1:0][TRI_BITS-1:0] t;
      for (int k = 0; k < TAB_DEPTH; k++) begin
         t[k] = TRI_BITS'((k * (k + 1)) / 2);
      end
      return t;
   endfunction

   // sums of squares k(k+1)(2k+1)/6
   function automatic logic [TAB_DEPTH-1:0][PYR_BITS-1:0] build_pyr();
      logic [TAB_DEPTH-1:0][PYR_BITS-1:0] t;
      for (int k = 0; k < TAB_DEPTH; k++) begin
         t[k] = PYR_BITS'((k * (k + 1) * (2 * k + 1)) / 6);
      end
      return t;
   endfunction

   localparam logic [VN_DEPTH-1:0][DEG_BITS-1:0]  VN_TAB  = build_vn_tab();
   localparam logic [TAB_DEPTH-1:0][TRI_BITS-1:0] TRI_TAB = build_tri();
   localparam logic [TAB_DEPTH-1:0][PYR_BITS-1:0] PYR_TAB = build_pyr();

endpackage

[hw/rtl/fsc_div.sv]
`include "fuzzy_steering_centroid_macros.svh"

module fsc_div #(
   parameter int HALF_UNIVERSE = fsc_pkg::HALF_UNIVERSE_DEF,
   parameter int QUOT_BITS     = $clog2(fsc_pkg::HALF_UNIVERSE_DEF + 1) + 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [fsc_pkg::MOMENT_BITS-2:0]     in_mag,
   input  logic [fsc_pkg::WEIGHT_BITS-1:0]     in_divisor,
   input  fsc_pkg::div_tag_type                in_tag,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [QUOT_BITS-1:0]                out_quot,
   output fsc_pkg::div_tag_type                out_tag
);
   import fsc_pkg::*;

   localparam int WB = WEIGHT_BITS;
   localparam int QB = QUOT_BITS;

   logic [QB-1:0]       valid_ff;
   logic [QB-1:0]       rdy;
   logic [WB-1:0]       rem_ff  [QB];
   logic [QB-1:0]       low_ff  [QB];
   logic [QB-1:0]       quot_ff [QB];
   logic [WB-1:0]       div_ff  [QB];
   div_tag_type         tag_ff  [QB];

   logic [QB-1:0]       src_valid;
   logic [WB-1:0]       src_rem  [QB];
   logic [QB-1:0]       src_low  [QB];
   logic [QB-1:0]       src_quot [QB];
   logic [WB-1:0]       src_div  [QB];
   div_tag_type         src_tag  [QB];

   logic [WB-1:0]       rem_in  [QB];
   logic [QB-1:0]       low_in  [QB];
   logic [QB-1:0]       quot_in [QB];

   // stall chain, a stage moves when empty or when its successor moves
   always_comb begin
      rdy[QB-1] = !valid_ff[QB-1] || out_ready;
      for (int j = QB - 2; j >= 0; j--) begin
         rdy[j] = !valid_ff[j] || rdy[j+1];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[QB-1];
   assign out_quot  = quot_ff[QB-1];
   assign out_tag   = tag_ff[QB-1];

   // stage sources: the dividend is mag * 256, its top bits seed the remainder
   always_comb begin
      src_valid[0] = in_valid;
      src_rem[0]   = WB'(in_mag >> (QB - 8));
      src_low[0]   = {in_mag[QB-9:0], 8'd0};
      src_quot[0]  = '0;
      src_div[0]   = in_divisor;
      src_tag[0]   = in_tag;
      for (int j = 1; j < QB; j++) begin
         src_valid[j] = valid_ff[j-1];
         src_rem[j]   = rem_ff[j-1];
         src_low[j]   = low_ff[j-1];
         src_quot[j]  = quot_ff[j-1];
         src_div[j]   = div_ff[j-1];
         src_tag[j]   = tag_ff[j-1];
      end
   end

   // one restoring step per stage
   always_comb begin
      for (int j = 0; j < QB; j++) begin
         logic [WB:0] trial;
         logic        fits;
         trial      = {src_rem[j], src_low[j][QB-1]};
         fits       = trial >= {1'b0, src_div[j]};
         rem_in[j]  = fits ? WB'(trial - {1'b0, src_div[j]}) : WB'(trial);
         low_in[j]  = src_low[j] << 1;
         quot_in[j] = {src_quot[j][QB-2:0], fits};
      end
   end

   // stage valid bits
   always_ff @(posedge clock) begin
      for (int j = 0; j < QB; j++) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            valid_ff[j] <= src_valid[j];
         end
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      for (int j = 0; j < QB; j++) begin
         if (rdy[j] && src_valid[j]) begin
            rem_ff[j]  <= rem_in[j];
            low_ff[j]  <= low_in[j];
            quot_ff[j] <= quot_in[j];
            div_ff[j]  <= src_div[j];
            tag_ff[j]  <= src_tag[j];
         end
      end
   end

   `FSC_ASSERT_NEXT(a_take_fills_first, in_valid && in_ready, valid_ff[0])
   `FSC_ASSERT_IMPLY(a_rem_below_divisor, valid_ff[QB-1] && !tag_ff[QB-1].zero, rem_ff[QB-1] < div_ff[QB-1])
   `FSC_ASSERT_IMPLY(a_quot_in_range, out_valid && !out_tag.zero, out_quot <= QB'(HALF_UNIVERSE * 256))

endmodule

[hw/rtl/fuzzy_steering_centroid.sv]
// Fuzzy steering controller: six distance readings per transaction in, one pair of
// wheel drives per transaction out. A new reading set is accepted every cycle unless the
// output stalls; each one passes stages a to d, the divider and stages e and f to the
// output register, where QUOT_BITS = clog2(HALF_UNIVERSE+1)+8 (14 at the default universe) is
// the number of stages of the pipelined restoring divider that forms the centroid, one quotient bit per stage.
// Configuration writes take effect at the edge they are made and should only be made
// while the pipeline is empty.
`include "fuzzy_steering_centroid_macros.svh"

module fuzzy_steering_centroid #(
   parameter int SENSOR_BITS   = fsc_pkg::SENSOR_BITS_DEF,
   parameter int HALF_UNIVERSE = fsc_pkg::HALF_UNIVERSE_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // left_side, left_diag, front_left, front_right, right_diag, right_side
   input  logic [((6*SENSOR_BITS+7)/8)*8-1:0]          req_tdata,
   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // left_drive, right_drive
   output logic [31:0]                                 rsp_tdata,
   // no_rule_fired
   output logic                                        rsp_tuser,
   input  logic                                        csr_wen,
   input  logic [0:0]                                  csr_addr,
   input  logic [fsc_pkg::CFG_BITS-1:0]                csr_wdata
);
   import fsc_pkg::*;

   localparam int QB = $clog2(HALF_UNIVERSE + 1) + 8;
   localparam int SW = QB + 2;
   localparam int AROUND_CNT = (HALF_UNIVERSE - 1 > AROUND_START) ?
                               HALF_UNIVERSE - 1 - AROUND_START : 0;
   localparam int AROUND_MOM = (HALF_UNIVERSE - 1 > AROUND_START) ?
      ((HALF_UNIVERSE - 1) * HALF_UNIVERSE) / 2 - (AROUND_START * (AROUND_START + 1)) / 2 : 0;
   localparam logic [K_BITS-1:0] CNT_NEG = K_BITS'(HALF_UNIVERSE);
   localparam logic [K_BITS-1:0] CNT_POS = K_BITS'(HALF_UNIVERSE - 1);

   // configuration registers
   logic [CFG_BITS-1:0] fwd_speed_ff;
   logic [CFG_BITS-1:0] gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_speed_ff <= FWD_SPEED_RESET;
         gain_ff      <= GAIN_RESET;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_addr))
            CSR_FORWARD_SPEED: fwd_speed_ff <= csr_wdata;
            CSR_STEERING_GAIN: gain_ff      <= csr_wdata;
            default:           fwd_speed_ff <= fwd_speed_ff;
         endcase
      end
   end

   // near degree: 256*off/3 as 85*off + off/3
   function automatic logic [DEG_BITS-1:0] near_of(input logic [11:0] d);
      logic [8:0]  off;
      logic [18:0] third;
      off = (d <= 12'(NEAR_MID)) ? 9'(d - 12'(NEAR_LO)) : 9'(12'(NEAR_HI) - d);
      third = 19'(off) * 19'd683;
      if (d <= 12'(NEAR_LO) || d >= 12'(NEAR_HI)) begin
         return '0;
      end
      return DEG_BITS'(15'(off) * 15'd85) + DEG_BITS'(third >> 11);
   endfunction

   function automatic logic [DEG_BITS-1:0] very_near_of(input logic [11:0] d);
      logic [6:0] idx;
      idx = 7'(d - 12'(NEAR_HI));
      if (d <= 12'(NEAR_HI)) begin
         return '0;
      end
      if (d >= 12'(VN_TOP)) begin
         return DEG_BITS'(FULL_DEG);
      end
      return VN_TAB[idx];
   endfunction

   // clipped ramp over points 1..cnt with step 256 or 512, in closed form
   function automatic ramp_sum_type ramp_sum(input logic [DEG_BITS-1:0] deg,
                                             input logic wide_step,
                                             input logic [K_BITS-1:0] cnt);
      logic [K_BITS-1:0]      k_raw;
      logic [K_BITS-1:0]      k;
      logic [WEIGHT_BITS-1:0] tri_part;
      logic [MOMENT_BITS-1:0] pyr_part;
      ramp_sum_type           r;
      k_raw    = wide_step ? K_BITS'(deg >> 9) : K_BITS'(deg >> 8);
      k        = (k_raw < cnt) ? k_raw : cnt;
      tri_part = wide_step ? (WEIGHT_BITS'(TRI_TAB[k]) << 9) : (WEIGHT_BITS'(TRI_TAB[k]) << 8);
      pyr_part = wide_step ? (MOMENT_BITS'(PYR_TAB[k]) << 9) : (MOMENT_BITS'(PYR_TAB[k]) << 8);
      r.weight = tri_part + WEIGHT_BITS'(cnt - k) * WEIGHT_BITS'(deg);
      r.moment = pyr_part + MOMENT_BITS'(deg) * MOMENT_BITS'(TRI_TAB[cnt] - TRI_TAB[k]);
      return r;
   endfunction

   function automatic logic [DRIVE_BITS-1:0] sat_drive(input logic signed [SW-1:0] v);
      if (v > SW'(DRIVE_MAX)) begin
         return DRIVE_BITS'(DRIVE_MAX);
      end
      if (v < SW'(DRIVE_MIN)) begin
         return DRIVE_BITS'(DRIVE_MIN);
      end
      return DRIVE_BITS'(v);
   endfunction

   // ready chain back from the output register
   logic a_ready, b_ready, c_ready, d_ready, e_ready, f_ready, div_in_ready;
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff, f_valid_ff;
   logic div_out_valid;

   assign f_ready    = !f_valid_ff || rsp_tready;
   assign e_ready    = !e_valid_ff || f_ready;
   assign d_ready    = !d_valid_ff || div_in_ready;
   assign c_ready    = !c_valid_ff || d_ready;
   assign b_ready    = !b_valid_ff || c_ready;
   assign a_ready    = !a_valid_ff || b_ready;
   assign req_tready = a_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
      end else begin
         if (a_ready) a_valid_ff <= req_tvalid;
         if (b_ready) b_valid_ff <= a_valid_ff;
         if (c_ready) c_valid_ff <= b_valid_ff;
         if (d_ready) d_valid_ff <= c_valid_ff;
         if (e_ready) e_valid_ff <= div_out_valid;
         if (f_ready) f_valid_ff <= e_valid_ff;
      end
   end

   // stage a: memberships and rule strengths
   logic [DEG_BITS-1:0] vn [6];
   logic [DEG_BITS-1:0] nr [6];
   logic [DEG_BITS-1:0] deg_r_in, deg_l_in, deg_rh_in, deg_lh_in, deg_ar_in;
   logic [DEG_BITS-1:0] deg_r_ff, deg_l_ff, deg_rh_ff, deg_lh_ff, deg_ar_ff;

   always_comb begin
      for (int s = 0; s < 6; s++) begin
         vn[s] = very_near_of(12'(req_tdata[s*SENSOR_BITS +: SENSOR_BITS]));
         nr[s] = near_of(12'(req_tdata[s*SENSOR_BITS +: SENSOR_BITS]));
      end
      deg_r_in  = (vn[0] > vn[1]) ? vn[0] : vn[1];
      deg_l_in  = (vn[4] > vn[5]) ? vn[4] : vn[5];
      deg_rh_in = (nr[0] > nr[1]) ? nr[0] : nr[1];
      deg_lh_in = (nr[4] > nr[5]) ? nr[4] : nr[5];
      deg_ar_in = (nr[2] < nr[3]) ? nr[2] : nr[3];
   end

   always_ff @(posedge clock) begin
      if (a_ready && req_tvalid) begin
         deg_r_ff  <= deg_r_in;
         deg_l_ff  <= deg_l_in;
         deg_rh_ff <= deg_rh_in;
         deg_lh_ff <= deg_lh_in;
         deg_ar_ff <= deg_ar_in;
      end
   end

   // stage b: weight and moment of each clipped set
   ramp_sum_type set_r_ff, set_l_ff, set_rh_ff, set_lh_ff;
   logic [WEIGHT_BITS-1:0] ar_weight_ff;
   logic [MOMENT_BITS-1:0] ar_moment_ff;

   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         set_r_ff     <= ramp_sum(deg_r_ff, 1'b1, CNT_NEG);
         set_l_ff     <= ramp_sum(deg_l_ff, 1'b1, CNT_POS);
         set_rh_ff    <= ramp_sum(deg_rh_ff, 1'b0, CNT_NEG);
         set_lh_ff    <= ramp_sum(deg_lh_ff, 1'b0, CNT_POS);
         ar_weight_ff <= WEIGHT_BITS'(deg_ar_ff) * WEIGHT_BITS'(AROUND_CNT);
         ar_moment_ff <= MOMENT_BITS'(deg_ar_ff) * MOMENT_BITS'(AROUND_MOM);
      end
   end

   // stage c: totals, turn-right sets sit on negative points
   logic [WEIGHT_BITS-1:0]        c_weight_ff;
   logic signed [MOMENT_BITS-1:0] c_moment_ff;

   always_ff @(posedge clock) begin
      if (c_ready && b_valid_ff) begin
         c_weight_ff <= set_r_ff.weight + set_l_ff.weight + set_rh_ff.weight
                      + set_lh_ff.weight + ar_weight_ff;
         c_moment_ff <= $signed(set_l_ff.moment + set_lh_ff.moment + ar_moment_ff
                      - set_r_ff.moment - set_rh_ff.moment);
      end
   end

   // stage d: sign and magnitude for the divider
   logic [MOMENT_BITS-2:0]  d_mag_ff;
   logic [WEIGHT_BITS-1:0]  d_weight_ff;
   div_tag_type             d_tag_ff;
   logic signed [MOMENT_BITS-1:0] c_abs;

   assign c_abs = (c_moment_ff < 0) ? -c_moment_ff : c_moment_ff;

   always_ff @(posedge clock) begin
      if (d_ready && c_valid_ff) begin
         d_mag_ff      <= c_abs[MOMENT_BITS-2:0];
         d_weight_ff   <= c_weight_ff;
         d_tag_ff.neg  <= c_moment_ff < 0;
         d_tag_ff.zero <= c_weight_ff == '0;
      end
   end

   // centroid magnitude, one quotient bit per stage
   logic [QB-1:0] div_quot;
   div_tag_type   div_tag;

   fsc_div #(
      .HALF_UNIVERSE (HALF_UNIVERSE),
      .QUOT_BITS     (QB)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (d_valid_ff),
      .in_ready   (div_in_ready),
      .in_mag     (d_mag_ff),
      .in_divisor (d_weight_ff),
      .in_tag     (d_tag_ff),
      .out_valid  (div_out_valid),
      .out_ready  (e_ready),
      .out_quot   (div_quot),
      .out_tag    (div_tag)
   );

   // stage e: gain product, zero weight forces the centroid to zero
   logic [QB+CFG_BITS-1:0] e_prod_ff;
   div_tag_type            e_tag_ff;

   always_ff @(posedge clock) begin
      if (e_ready && div_out_valid) begin
         e_prod_ff <= div_tag.zero ? '0 : (QB + CFG_BITS)'(div_quot) * (QB + CFG_BITS)'(gain_ff);
         e_tag_ff  <= div_tag;
      end
   end

   // stage f: round, apply sign, saturate into the output register
   logic [QB+CFG_BITS:0]   rounded;
   logic [QB-1:0]          term_mag;
   logic signed [SW-1:0]   term_s;
   logic signed [SW-1:0]   speed_s;
   logic [DRIVE_BITS-1:0]  left_ff, right_ff;
   logic                   zero_ff;

   always_comb begin
      rounded  = (QB + CFG_BITS + 1)'(e_prod_ff) + (QB + CFG_BITS + 1)'(2048);
      term_mag = rounded[QB+11:12];
      term_s   = e_tag_ff.neg ? -$signed(SW'(term_mag)) : $signed(SW'(term_mag));
      speed_s  = $signed(SW'(fwd_speed_ff));
   end

   always_ff @(posedge clock) begin
      if (f_ready && e_valid_ff) begin
         left_ff  <= sat_drive(speed_s - term_s);
         right_ff <= sat_drive(speed_s + term_s);
         zero_ff  <= e_tag_ff.zero;
      end
   end

   assign rsp_tvalid = f_valid_ff;
   assign rsp_tdata  = {6'd0, right_ff, left_ff};
   assign rsp_tuser  = zero_ff;

   `FSC_ASSERT_IMPLY(a_idle_drives_equal, rsp_tvalid && rsp_tuser, rsp_tdata[12:0] == rsp_tdata[25:13])
   `FSC_ASSERT_NEXT(a_accept_fills_stage, req_tvalid && req_tready, a_valid_ff)
   `FSC_ASSERT_IMPLY(a_zero_weight_no_moment, c_valid_ff && (c_weight_ff == '0), c_moment_ff == '0)

endmodule

[tb/fuzzy_steering_centroid_tb.sv]
`timescale 1ns / 100ps

module fuzzy_steering_centroid_tb;
   import fsc_pkg::*;

   localparam int SB = 10;
   localparam int HU = 50;
   localparam int LATENCY = 6 + 14;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 1530;

   typedef struct {
      logic [12:0] left_drive;
      logic [12:0] right_drive;
      logic        no_rule_fired;
   } drive_pair_type;

   // steering predictor and queue of expected wheel drives
   class drive_scoreboard;
      logic [11:0] fwd_speed;
      logic [11:0] gain;
      drive_pair_type pending_drives[$];
      int errors;

      function void set_reg(csr_index_type idx, logic [11:0] v);
         if (idx == CSR_FORWARD_SPEED) fwd_speed = v;
         else gain = v;
      endfunction

      function longint vn_deg(longint d);
         if (d <= 900) return 0;
         if (d >= 1023) return 25600;
         return ((d - 900) * 25600) / 123;
      endfunction

      function longint near_deg(longint d);
         if (d <= 300 || d >= 900) return 0;
         if (d <= 600) return ((d - 300) * 256) / 3;
         return ((900 - d) * 256) / 3;
      endfunction

      function longint mx(longint a, longint b);
         return a > b ? a : b;
      endfunction

      function longint mn(longint a, longint b);
         return a < b ? a : b;
      endfunction

      function longint sat(longint v);
         if (v > DRIVE_MAX) return DRIVE_MAX;
         if (v < DRIVE_MIN) return DRIVE_MIN;
         return v;
      endfunction

      // note an accepted sensor frame
      function void note_frame(logic [SB-1:0] s[6]);
         longint dr, dl, drh, dlh, dar, w, wsum, msum, cen, mag, term;
         drive_pair_type e;
         dr  = mx(vn_deg(s[0]), vn_deg(s[1]));
         dl  = mx(vn_deg(s[4]), vn_deg(s[5]));
         drh = mx(near_deg(s[0]), near_deg(s[1]));
         dlh = mx(near_deg(s[4]), near_deg(s[5]));
         dar = mn(near_deg(s[2]), near_deg(s[3]));
         wsum = 0;
         msum = 0;
         for (int i = -HU; i < HU; i++) begin
            w = mn(i < 0 ? -2 * i * 256 : 0, dr) + mn(i >= 0 ? 2 * i * 256 : 0, dl)
              + mn(i < 0 ? -i * 256 : 0, drh) + mn(i >= 0 ? i * 256 : 0, dlh)
              + mn(i > AROUND_START ? 25600 : 0, dar);
            wsum += w;
            msum += w * i;
         end
         cen = 0;
         if (wsum > 0) cen = (msum * 256) / wsum;
         mag = ((cen < 0 ? -cen : cen) * longint'(gain) + 2048) >>> 12;
         term = cen < 0 ? -mag : mag;
         e.left_drive = 13'(sat(longint'(fwd_speed) - term));
         e.right_drive = 13'(sat(longint'(fwd_speed) + term));
         e.no_rule_fired = (wsum == 0);
         pending_drives.push_back(e);
      endfunction

      // compare one result against the oldest expectation
      function void check_drive(drive_pair_type a);
         drive_pair_type e;
         if (pending_drives.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result l=%0d r=%0d nf=%0d",
               $signed(a.left_drive), $signed(a.right_drive), a.no_rule_fired);
            return;
         end
         e = pending_drives.pop_front();
         if (a.left_drive !== e.left_drive || a.right_drive !== e.right_drive ||
             a.no_rule_fired !== e.no_rule_fired) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp l=%0d r=%0d nf=%0d got l=%0d r=%0d nf=%0d",
                  $signed(e.left_drive), $signed(e.right_drive), e.no_rule_fired,
                  $signed(a.left_drive), $signed(a.right_drive), a.no_rule_fired);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_wen = 0;
   logic [0:0] csr_addr = '0;
   logic [11:0] csr_wdata = '0;

   drive_scoreboard sb = new();
   int idle_cycles = 0;
   bit rsp_noidle = 0;

   fuzzy_steering_centroid u_dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // result side: sample on rising edge, random stalls unless rsp_noidle is set
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_drive(drive_pair_type'{rsp_tdata[12:0], rsp_tdata[25:13], rsp_tuser});
   end

   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         gap = rsp_noidle ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // valid stays high after the transaction until the next gap or drain
   task automatic send_frame(logic [SB-1:0] s[6], int gap);
      logic [SB-1:0] q[6];
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {4'b0, s[5], s[4], s[3], s[2], s[1], s[0]};
      req_tvalid <= 1;
      q = s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_frame(q);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending_drives.size() != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [11:0] v);
      csr_wen <= 1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.set_reg(idx, v);
      @(negedge clock);
      csr_wen <= 0;
      @(negedge clock);
   endtask

   function automatic logic [SB-1:0] rand_reading();
      unique case ($urandom_range(0, 5))
         0: return SB'($urandom_range(0, 1023));
         1: return SB'($urandom_range(880, 1023));
         2: return SB'($urandom_range(290, 910));
         3: return SB'($urandom_range(0, 300));
         4: return SB'($urandom_range(1015, 1023));
         default: return SB'($urandom_range(590, 610));
      endcase
   endfunction

   initial begin
      logic [SB-1:0] s[6];
      logic [11:0] spd[5];
      logic [11:0] gn[5];
      int dir[12];
      spd = '{12'd1024, 12'd0, 12'd2048, 12'd4095, 12'($urandom_range(0, 4095))};
      gn = '{12'd410, 12'd4095, 12'd0, 12'd4095, 12'($urandom_range(0, 4095))};
      dir = '{0, 1023, 300, 301, 600, 899, 900, 901, 1022, 450, 750, 960};
      sb.fwd_speed = FWD_SPEED_RESET;
      sb.gain = GAIN_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: breakpoints on each sensor, no-rule, turn-around
      write_reg(CSR_FORWARD_SPEED, 12'd1024);
      write_reg(CSR_STEERING_GAIN, 12'd410);
      for (int k = 0; k < 12; k++) begin
         foreach (s[j]) s[j] = SB'(dir[k]);
         send_frame(s, 0);
      end
      for (int j = 0; j < 6; j++) begin
         foreach (s[m]) s[m] = '0;
         s[j] = SB'(j < 2 || j > 3 ? 1023 : 600);
         if (j == 2 || j == 3) begin
            s[2] = 10'd600;
            s[3] = 10'd450;
         end
         send_frame(s, $urandom_range(0, 3));
      end
      s = '{10'd1023, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1023};
      send_frame(s, 0);
      s = '{10'd1023, 10'd1023, 10'd0, 10'd0, 10'd0, 10'd0};
      send_frame(s, 0);
      // wait for everything to come back before new settings
      drain();
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(CSR_FORWARD_SPEED, spd[ph]);
         write_reg(CSR_STEERING_GAIN, gn[ph]);
         rsp_noidle = (ph == 2);
         for (int n = 0; n < N_RANDOM / 5; n++) begin
            foreach (s[j]) s[j] = rand_reading();
            send_frame(s, (ph == 1 || ph == 2) ? 0 : $urandom_range(0, 19));
         end
         drain();
      end
      rsp_noidle = 0;
      drain();
      if (sb.errors == 0 && sb.pending_drives.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[fuzzy_steering_centroid.f]
+incdir+hw/rtl
hw/rtl/fsc_pkg.sv
hw/rtl/fsc_div.sv
hw/rtl/fuzzy_steering_centroid.sv
tb/fuzzy_steering_centroid_tb.sv
